[rtl/core/two_class_age_ordered_queue_macros.svh]
// Assertion macros shared by the queue's checker.
`ifndef TWO_CLASS_AGE_ORDERED_QUEUE_MACROS_SVH
`define TWO_CLASS_AGE_ORDERED_QUEUE_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define TCAOQ_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define TCAOQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/tcaoq_pkg.sv]
// Shared types and constants of the two-class age-ordered queue.
package tcaoq_pkg;

   // Default configuration
   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int TAG_BITS_DEF    = 16;
   localparam int SEQ_BITS_DEF    = 16;

   // Request commands
   typedef enum logic [1:0] {
      CMD_ENQUEUE     = 2'd0,
      CMD_DEQ_OLDEST  = 2'd1,
      CMD_DEQ_FIRST   = 2'd2,
      CMD_DEQ_SECOND  = 2'd3
   } cmd_type;

   // Result status codes
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // Decoded request handed from the front end to the back end
   typedef struct packed {
      logic enq;     // append to a class FIFO
      logic oldest;  // dequeue whichever head is older
      logic cls;     // class to append to, or preferred class on dequeue
   } job_type;

endpackage

[rtl/core/tcaoq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tcaoq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/tcaoq_front.sv]
// Front end: accepts requests, decodes them and holds them in a two-entry queue.
module tcaoq_front import tcaoq_pkg::*; #(
   parameter int TAG_BITS = TAG_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_command,
   input  logic                req_item_class,
   input  logic [TAG_BITS-1:0] req_item_tag,
   output logic                job_valid,
   output job_type             job,
   output logic [TAG_BITS-1:0] job_tag,
   input  logic                job_pop
);

   localparam int QDEPTH   = 2;
   localparam int QPTR     = $clog2(QDEPTH);
   localparam int QCNT     = $clog2(QDEPTH + 1);

   job_type             job_ff [QDEPTH];
   logic [TAG_BITS-1:0] tag_ff [QDEPTH];
   logic [QPTR-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPTR-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QCNT-1:0]     cnt_ff, cnt_in;
   logic                push;
   job_type             decoded;

   // Decode the command into the back end's job fields
   always_comb begin
      decoded = '0;
      case (cmd_type'(req_command))
         CMD_ENQUEUE: begin
            decoded.enq = 1'b1;
            decoded.cls = req_item_class;
         end
         CMD_DEQ_OLDEST: begin
            decoded.oldest = 1'b1;
         end
         CMD_DEQ_FIRST: begin
            decoded.cls = 1'b0;
         end
         CMD_DEQ_SECOND: begin
            decoded.cls = 1'b1;
         end
         default: begin
            decoded = '0;
         end
      endcase
   end

   assign req_stall = (cnt_ff == QCNT'(QDEPTH));
   assign push      = req_valid && !req_stall;

   // Queue pointers and fill count
   always_comb begin
      wr_ptr_in = push    ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = job_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      case ({push, job_pop})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Queue payload
   always_ff @(posedge clock) begin
      if (push) begin
         job_ff[wr_ptr_ff] <= decoded;
         tag_ff[wr_ptr_ff] <= req_item_tag;
      end
   end

   assign job_valid = (cnt_ff != '0);
   assign job       = job_ff[rd_ptr_ff];
   assign job_tag   = tag_ff[rd_ptr_ff];

endmodule

[rtl/core/tcaoq_back.sv]
// Back end: two class FIFOs in RAM, sequence stamping, oldest-first pop, result register.
module tcaoq_back import tcaoq_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   parameter int TAG_BITS    = TAG_BITS_DEF,
   parameter int SEQ_BITS    = SEQ_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                job_valid,
   input  job_type             job,
   input  logic [TAG_BITS-1:0] job_tag,
   output logic                job_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_status,
   output logic [TAG_BITS-1:0] rsp_out_tag,
   output logic                rsp_out_class,
   output logic [SEQ_BITS-1:0] rsp_out_sequence
);

   localparam int PTR_BITS  = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS  = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_BITS  = PTR_BITS + 1;
   localparam int WORD_BITS = TAG_BITS + SEQ_BITS;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_READ = 2'b10
   } state_type;

   state_type            state_ff, state_in;
   logic [PTR_BITS-1:0]  head0_ff, head0_in, head1_ff, head1_in;
   logic [CNT_BITS-1:0]  cnt0_ff, cnt0_in, cnt1_ff, cnt1_in;
   logic [SEQ_BITS-1:0]  seq_ff, seq_in;
   logic                 pend_oldest_ff, pend_oldest_in;
   logic                 pend_cls_ff, pend_cls_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [TAG_BITS-1:0]  rsp_tag_ff, rsp_tag_in;
   logic                 rsp_class_ff, rsp_class_in;
   logic [SEQ_BITS-1:0]  rsp_seq_ff, rsp_seq_in;

   logic [SUM_BITS-1:0]  sum0, sum1, sum0_adj, sum1_adj;
   logic [PTR_BITS-1:0]  tail0, tail1, head0_nxt, head1_nxt;
   logic                 full0, full1, empty0, empty1;
   logic                 wr0, wr1;
   logic [WORD_BITS-1:0] wr_word, rd0, rd1;
   logic [SEQ_BITS-1:0]  seq0, seq1, age_diff;
   logic [TAG_BITS-1:0]  tag0, tag1;
   logic                 first_older, take1, out_free;

   // Tail pointers: head plus count, wrapped at the depth
   always_comb begin
      sum0     = SUM_BITS'(head0_ff) + SUM_BITS'(cnt0_ff);
      sum1     = SUM_BITS'(head1_ff) + SUM_BITS'(cnt1_ff);
      sum0_adj = (sum0 >= SUM_BITS'(QUEUE_DEPTH)) ? sum0 - SUM_BITS'(QUEUE_DEPTH) : sum0;
      sum1_adj = (sum1 >= SUM_BITS'(QUEUE_DEPTH)) ? sum1 - SUM_BITS'(QUEUE_DEPTH) : sum1;
      tail0    = sum0_adj[PTR_BITS-1:0];
      tail1    = sum1_adj[PTR_BITS-1:0];
   end

   assign head0_nxt = (head0_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : head0_ff + 1'b1;
   assign head1_nxt = (head1_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : head1_ff + 1'b1;
   assign full0     = (cnt0_ff == CNT_BITS'(QUEUE_DEPTH));
   assign full1     = (cnt1_ff == CNT_BITS'(QUEUE_DEPTH));
   assign empty0    = (cnt0_ff == '0);
   assign empty1    = (cnt1_ff == '0);

   // Class stores: word is {tag, sequence}, read port always on the head
   assign wr_word = {job_tag, seq_ff};

   tcaoq_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_store0 (
      .clock   (clock),
      .wr_en   (wr0),
      .wr_addr (tail0),
      .wr_data (wr_word),
      .rd_addr (head0_ff),
      .rd_data (rd0)
   );

   tcaoq_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_store1 (
      .clock   (clock),
      .wr_en   (wr1),
      .wr_addr (tail1),
      .wr_data (wr_word),
      .rd_addr (head1_ff),
      .rd_data (rd1)
   );

   // Head fields and age compare over the wrapping sequence difference
   always_comb begin
      seq0        = rd0[SEQ_BITS-1:0];
      seq1        = rd1[SEQ_BITS-1:0];
      tag0        = rd0[WORD_BITS-1:SEQ_BITS];
      tag1        = rd1[WORD_BITS-1:SEQ_BITS];
      age_diff    = seq1 - seq0;
      first_older = (age_diff != '0) && !age_diff[SEQ_BITS-1];
      if (empty0) begin
         take1 = 1'b1;
      end else if (empty1) begin
         take1 = 1'b0;
      end else if (pend_oldest_ff) begin
         take1 = !first_older;
      end else begin
         take1 = pend_cls_ff;
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Sequencer
   always_comb begin
      state_in       = state_ff;
      head0_in       = head0_ff;
      head1_in       = head1_ff;
      cnt0_in        = cnt0_ff;
      cnt1_in        = cnt1_ff;
      seq_in         = seq_ff;
      pend_oldest_in = pend_oldest_ff;
      pend_cls_in    = pend_cls_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_tag_in     = rsp_tag_ff;
      rsp_class_in   = rsp_class_ff;
      rsp_seq_in     = rsp_seq_ff;
      job_pop        = 1'b0;
      wr0            = 1'b0;
      wr1            = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (job_valid && job.enq && out_free) begin
               // Enqueue: stamp, append unless full, answer at once
               job_pop       = 1'b1;
               seq_in        = seq_ff + 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_tag_in    = '0;
               rsp_class_in  = 1'b0;
               rsp_seq_in    = '0;
               if (job.cls ? full1 : full0) begin
                  rsp_status_in = ST_FULL;
               end else begin
                  rsp_status_in = ST_OK;
                  wr0           = !job.cls;
                  wr1           = job.cls;
                  if (job.cls) begin
                     cnt1_in = cnt1_ff + 1'b1;
                  end else begin
                     cnt0_in = cnt0_ff + 1'b1;
                  end
               end
            end else if (job_valid && !job.enq) begin
               // Dequeue: wait in S_READ for the head words
               job_pop        = 1'b1;
               pend_oldest_in = job.oldest;
               pend_cls_in    = job.cls;
               state_in       = S_READ;
            end
         end
         S_READ: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               if (empty0 && empty1) begin
                  rsp_status_in = ST_EMPTY;
                  rsp_tag_in    = '0;
                  rsp_class_in  = 1'b0;
                  rsp_seq_in    = '0;
               end else begin
                  rsp_status_in = ST_OK;
                  rsp_class_in  = take1;
                  rsp_tag_in    = take1 ? tag1 : tag0;
                  rsp_seq_in    = take1 ? seq1 : seq0;
                  if (take1) begin
                     head1_in = head1_nxt;
                     cnt1_in  = cnt1_ff - 1'b1;
                  end else begin
                     head0_in = head0_nxt;
                     cnt0_in  = cnt0_ff - 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head0_ff     <= '0;
         head1_ff     <= '0;
         cnt0_ff      <= '0;
         cnt1_ff      <= '0;
         seq_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head0_ff     <= head0_in;
         head1_ff     <= head1_in;
         cnt0_ff      <= cnt0_in;
         cnt1_ff      <= cnt1_in;
         seq_ff       <= seq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      pend_oldest_ff <= pend_oldest_in;
      pend_cls_ff    <= pend_cls_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_tag_ff     <= rsp_tag_in;
      rsp_class_ff   <= rsp_class_in;
      rsp_seq_ff     <= rsp_seq_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_tag      = rsp_tag_ff;
   assign rsp_out_class    = rsp_class_ff;
   assign rsp_out_sequence = rsp_seq_ff;

endmodule

[rtl/core/two_class_age_ordered_queue.sv]
// Two-class age-ordered queue: top level joining the request front end and the FIFO back end.
// Each request gives exactly one result. Requests enter a two-entry command queue in the
// front end, so req_stall rises only when two requests wait there. The back end runs one
// request at a time: an enqueue is answered from S_IDLE, a dequeue first passes through
// S_READ, because the head words come out of the class stores through their registered
// read port. The result register holds one result; while it is stalled the back end waits
// and the front end keeps taking requests until its queue fills. Both stores are undefined
// after reset and need no clearing pass; only the words of occupied entries are ever used.
module two_class_age_ordered_queue import tcaoq_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   parameter int TAG_BITS    = TAG_BITS_DEF,
   parameter int SEQ_BITS    = SEQ_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_command,
   input  logic                req_item_class,
   input  logic [TAG_BITS-1:0] req_item_tag,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_status,
   output logic [TAG_BITS-1:0] rsp_out_tag,
   output logic                rsp_out_class,
   output logic [SEQ_BITS-1:0] rsp_out_sequence
);

   logic                job_valid;
   job_type             job;
   logic [TAG_BITS-1:0] job_tag;
   logic                job_pop;

   tcaoq_front #(
      .TAG_BITS (TAG_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_item_class (req_item_class),
      .req_item_tag   (req_item_tag),
      .job_valid      (job_valid),
      .job            (job),
      .job_tag        (job_tag),
      .job_pop        (job_pop)
   );

   tcaoq_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .TAG_BITS    (TAG_BITS),
      .SEQ_BITS    (SEQ_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .job_valid        (job_valid),
      .job              (job),
      .job_tag          (job_tag),
      .job_pop          (job_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_out_tag      (rsp_out_tag),
      .rsp_out_class    (rsp_out_class),
      .rsp_out_sequence (rsp_out_sequence)
   );

endmodule

[rtl/core/tcaoq_checker.sv]
// Port-level checker of the two-class age-ordered queue, bound to the top level.
`include "two_class_age_ordered_queue_macros.svh"

module tcaoq_checker import tcaoq_pkg::*; #(
   parameter int TAG_BITS = TAG_BITS_DEF,
   parameter int SEQ_BITS = SEQ_BITS_DEF
) (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic [1:0]          req_command,
   input logic                req_item_class,
   input logic [TAG_BITS-1:0] req_item_tag,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [1:0]          rsp_status,
   input logic [TAG_BITS-1:0] rsp_out_tag,
   input logic                rsp_out_class,
   input logic [SEQ_BITS-1:0] rsp_out_sequence
);

   // A stalled result holds
   `TCAOQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_status) && $stable(rsp_out_tag) && $stable(rsp_out_class) && $stable(rsp_out_sequence),
      "stalled result changed")

   // Empty and full results carry no item
   `TCAOQ_ASSERT_NOW(a_err_zero, rsp_valid && rsp_status != ST_OK,
      rsp_out_tag == '0 && !rsp_out_class && rsp_out_sequence == '0,
      "error result carries item fields")

   // Both sides come out of reset idle
   `TCAOQ_ASSERT_NOW(a_reset_idle, $past(reset), !rsp_valid && !req_stall,
      "not idle after reset")

   // The command queue fills only on an accepted request
   `TCAOQ_ASSERT_NOW(a_stall_rise, $rose(req_stall), $past(req_valid && !req_stall),
      "stall rose without an accepted request")

endmodule

bind two_class_age_ordered_queue tcaoq_checker #(
   .TAG_BITS (TAG_BITS),
   .SEQ_BITS (SEQ_BITS)
) u_checker (.*);
